@@ design/dpf_pkg.sv @@
// Package for the download page framer.
// Holds sizing constants, command codes and the queue entry type.
// No dependencies.
package dpf_pkg;

	localparam int MAX_PAGE = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int DIV_STEPS = 24;
	localparam logic [7:0] RESERVED_BYTE = 8'h3C;

	localparam logic [1:0] CFG_FILE_SIZE = 2'd0;
	localparam logic [1:0] CFG_PAGE_SIZE = 2'd1;
	localparam logic [1:0] CFG_PROGRESS_SCALE = 2'd2;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef enum logic {
		CMD_DATA,
		CMD_PAGE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [6:0] position;
		logic [7:0] data;
		logic [15:0] start;
		logic [15:0] new_addr;
		logic [7:0] sum;
		logic [6:0] count;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef struct packed {
		logic [6:0] position;
		logic [7:0] value;
		logic last;
		logic [6:0] answer_count;
		logic progress_saturated;
	} res_t;

endpackage

@@ design/dpf_ifs.sv @@
// Valid/ready channel interfaces of the download page framer.
// Depends on nothing; one interface for input words, one for result words.
interface dpf_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [7:0] data_byte;
	logic page_end;
	modport source(output valid, action, data_byte, page_end, input ready);
	modport sink(input valid, action, data_byte, page_end, output ready);
endinterface

interface dpf_out_if;
	logic valid;
	logic ready;
	logic [6:0] position;
	logic [7:0] value;
	logic last;
	logic [6:0] answer_count;
	logic progress_saturated;
	modport source(output valid, position, value, last, answer_count, progress_saturated,
		input ready);
	modport sink(input valid, position, value, last, answer_count, progress_saturated,
		output ready);
endinterface

@@ design/dpf_front.sv @@
// Front end of the download page framer: accepts input words, tracks the page
// state and pushes one command per data byte into the queue.
// Depends on dpf_pkg and dpf_in_if.
module dpf_front (
	input logic clk,
	input logic arst_n,
	dpf_in_if.sink item,
	input logic [6:0] page_size,
	input dpf_pkg::queue_status_t qstat,
	output logic push,
	output dpf_pkg::cmd_t push_cmd
);
	import dpf_pkg::*;

	logic [15:0] addr_q;
	logic [7:0] sum_q;
	logic [6:0] count_q;

	logic [6:0] lim;
	logic [7:0] n;
	logic ends;
	logic accept;
	logic [7:0] sum_new;
	logic [15:0] new_addr;

	always_comb begin
		if (page_size == 7'd0) begin
			lim = 7'd1;
		end else if (page_size > 7'(MAX_PAGE)) begin
			lim = 7'(MAX_PAGE);
		end else begin
			lim = page_size;
		end
	end

	assign n = {1'b0, count_q} + 8'd1;
	assign ends = item.page_end || (n >= {1'b0, lim});
	assign sum_new = sum_q + item.data_byte;
	assign new_addr = addr_q + {8'd0, n};

	assign item.ready = !qstat.full;
	assign accept = item.valid && item.ready;
	assign push = accept && (item.action == ACT_DATA);

	always_comb begin
		push_cmd.kind = ends ? CMD_PAGE : CMD_DATA;
		push_cmd.position = count_q + 7'd4;
		push_cmd.data = item.data_byte;
		push_cmd.start = addr_q;
		push_cmd.new_addr = new_addr;
		push_cmd.sum = sum_new;
		push_cmd.count = 7'(n + 8'd5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (item.action == ACT_START) begin
				addr_q <= '0;
				sum_q <= '0;
				count_q <= '0;
			end else if (ends) begin
				addr_q <= new_addr;
				sum_q <= '0;
				count_q <= '0;
			end else begin
				sum_q <= sum_new;
				count_q <= n[6:0];
			end
		end
	end

endmodule

@@ design/dpf_queue.sv @@
// Short command queue between the front and back ends of the framer.
// Depends on dpf_pkg for the entry type and depth.
module dpf_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dpf_pkg::cmd_t push_cmd,
	input logic pop,
	output dpf_pkg::cmd_t head,
	output dpf_pkg::queue_status_t qstat
);
	import dpf_pkg::*;

	cmd_t entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0] fill_q;

	assign head = entry_q[rd_q];
	assign qstat.empty = (fill_q == '0);
	assign qstat.full = (fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ design/dpf_back.sv @@
// Back end of the framer: drains the queue, computes the progress byte with a
// single multiply and a bit-serial divider, and sends result words.
// Depends on dpf_pkg and dpf_out_if.
module dpf_back (
	input logic clk,
	input logic arst_n,
	input logic [15:0] file_size,
	input logic [7:0] progress_scale,
	input dpf_pkg::cmd_t head,
	input dpf_pkg::queue_status_t qstat,
	output logic pop,
	dpf_out_if.source result
);
	import dpf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DATA,
		ST_LO,
		ST_HI,
		ST_PROG,
		ST_RSV,
		ST_SUM
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [23:0] prod_q;
	logic [15:0] rem_q;
	logic [4:0] step_q;
	logic [7:0] prog_q;
	logic sat_q;
	logic valid_q;
	res_t out_q;

	logic can_load;
	logic load_word;
	logic [23:0] prod_full;
	logic [16:0] rem_sh;
	logic ge;
	logic [15:0] rem_nx;
	logic [23:0] prod_nx;
	logic [7:0] chk;

	assign can_load = !valid_q || result.ready;
	assign pop = (state_q == ST_IDLE) && !qstat.empty
		&& ((head.kind == CMD_PAGE) || can_load);

	always_comb begin
		unique case (state_q) inside
			ST_IDLE: load_word = pop && (head.kind == CMD_DATA);
			ST_DATA, ST_LO, ST_HI, ST_PROG, ST_RSV, ST_SUM: load_word = can_load;
			default: load_word = 1'b0;
		endcase
	end

	assign prod_full = 24'({1'b0, progress_scale} + 9'd1) * 24'(cmd_q.new_addr);
	assign rem_sh = {rem_q, prod_q[23]};
	assign ge = rem_sh >= {1'b0, file_size};
	assign rem_nx = ge ? 16'(rem_sh - {1'b0, file_size}) : rem_sh[15:0];
	assign prod_nx = {prod_q[22:0], ge};
	assign chk = cmd_q.sum + cmd_q.start[7:0] + cmd_q.start[15:8] + prog_q + RESERVED_BYTE;

	assign result.valid = valid_q;
	assign result.position = out_q.position;
	assign result.value = out_q.value;
	assign result.last = out_q.last;
	assign result.answer_count = out_q.answer_count;
	assign result.progress_saturated = out_q.progress_saturated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			step_q <= '0;
			cmd_q <= '0;
			prod_q <= '0;
			rem_q <= '0;
			prog_q <= '0;
			sat_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (load_word) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.kind == CMD_DATA) begin
							out_q <= '{head.position, head.data, 1'b1, 7'd0, 1'b0};
						end else begin
							cmd_q <= head;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q <= prod_full;
					rem_q <= '0;
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					prod_q <= prod_nx;
					rem_q <= rem_nx;
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DIV_STEPS - 1)) begin
						if ((file_size == 16'd0) || (|prod_nx[23:8])) begin
							prog_q <= 8'hFF;
							sat_q <= 1'b1;
						end else begin
							prog_q <= prod_nx[7:0];
							sat_q <= 1'b0;
						end
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (can_load) begin
						out_q <= '{cmd_q.position, cmd_q.data, 1'b0, cmd_q.count, sat_q};
						state_q <= ST_LO;
					end
				end
				ST_LO: begin
					if (can_load) begin
						out_q <= '{7'd0, cmd_q.start[7:0], 1'b0, cmd_q.count, sat_q};
						state_q <= ST_HI;
					end
				end
				ST_HI: begin
					if (can_load) begin
						out_q <= '{7'd1, cmd_q.start[15:8], 1'b0, cmd_q.count, sat_q};
						state_q <= ST_PROG;
					end
				end
				ST_PROG: begin
					if (can_load) begin
						out_q <= '{7'd2, prog_q, 1'b0, cmd_q.count, sat_q};
						state_q <= ST_RSV;
					end
				end
				ST_RSV: begin
					if (can_load) begin
						out_q <= '{7'd3, RESERVED_BYTE, 1'b0, cmd_q.count, sat_q};
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (can_load) begin
						out_q <= '{cmd_q.position + 7'd1, chk, 1'b1, cmd_q.count, sat_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/download_page_framer.sv @@
// A data byte that does not end a page is written into the queue, then popped into
// the output register that gives its word. Bytes are taken one per cycle while the
// four-entry queue has room. A page-ending byte holds the back end through a dequeue,
// a multiply step, 24 divider steps and six word states; the front queues bytes meanwhile.
// Reset clears the page state, the queue and the output register, and loads the
// configuration registers with file size 0, page size 64 and progress scale 0.
module download_page_framer (
	input logic clk,
	input logic arst_n,
	dpf_in_if.sink item,
	dpf_out_if.source result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	import dpf_pkg::*;

	logic [15:0] file_size_q;
	logic [6:0] page_size_q;
	logic [7:0] progress_scale_q;

	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;
	queue_status_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
			page_size_q <= 7'd64;
			progress_scale_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILE_SIZE: file_size_q <= cfg_data;
				CFG_PAGE_SIZE: page_size_q <= cfg_data[6:0];
				CFG_PROGRESS_SCALE: progress_scale_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	dpf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.page_size(page_size_q),
		.qstat(qstat),
		.push(push),
		.push_cmd(push_cmd)
	);

	dpf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	dpf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.file_size(file_size_q),
		.progress_scale(progress_scale_q),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.result(result)
	);

endmodule
